// ----- rtl/pli_pkg.sv -----
`timescale 1ns / 1ps
package pli_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CNT_W-1:0] MAX_POINTS_CNT = CNT_W'(MAX_POINTS);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXTRAP_EN   = 2'd1;

   // result kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_EXACT  = 2'd1;
   localparam logic [1:0] KIND_INTERP = 2'd2;
   localparam logic [1:0] KIND_EXTRAP = 2'd3;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // search record travelling along the cell row
   typedef struct packed {
      logic              vld;
      logic              exact_en;
      logic [DATA_W-1:0] qx;
      logic              hit;
      logic [DATA_W-1:0] hit_y;
      logic              has_lo;
      logic [DATA_W-1:0] lo_x;
      logic [DATA_W-1:0] lo_y;
      logic              has_hi;
      logic [DATA_W-1:0] hi_x;
      logic [DATA_W-1:0] hi_y;
   } scan_rec_type;

   // operands for one line evaluation
   typedef struct packed {
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] x0;
      logic [DATA_W-1:0] y0;
      logic [DATA_W-1:0] x1;
      logic [DATA_W-1:0] y1;
   } line_req_type;

endpackage

// ----- rtl/pli_cell.sv -----
`timescale 1ns / 1ps
module pli_cell import pli_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     cell_index,
   input  logic [CNT_W-1:0]     n_eff,
   input  logic                 wr_en,
   input  logic [DATA_W-1:0]    wr_x,
   input  logic [DATA_W-1:0]    wr_y,
   input  scan_rec_type         rec_in,
   output scan_rec_type         rec_out
);

   logic [DATA_W-1:0] px_ff, py_ff;
   scan_rec_type      rec_ff, rec_in_upd;
   logic              active;

   assign active = {1'b0, cell_index} < n_eff;

   always_comb begin
      rec_in_upd = rec_in;
      if (active && !rec_in.hit) begin
         if (rec_in.exact_en && px_ff == rec_in.qx) begin
            rec_in_upd.hit   = 1'b1;
            rec_in_upd.hit_y = py_ff;
         end else begin
            if ($signed(px_ff) < $signed(rec_in.qx) &&
                (!rec_in.has_lo || $signed(px_ff) > $signed(rec_in.lo_x))) begin
               rec_in_upd.has_lo = 1'b1;
               rec_in_upd.lo_x   = px_ff;
               rec_in_upd.lo_y   = py_ff;
            end
            if ($signed(px_ff) > $signed(rec_in.qx) &&
                (!rec_in.has_hi || $signed(px_ff) < $signed(rec_in.hi_x))) begin
               rec_in_upd.has_hi = 1'b1;
               rec_in_upd.hi_x   = px_ff;
               rec_in_upd.hi_y   = py_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         px_ff <= wr_x;
         py_ff <= wr_y;
      end
      if (reset) begin
         rec_ff.vld <= 1'b0;
      end else begin
         rec_ff <= rec_in_upd;
      end
   end

   assign rec_out = rec_ff;

endmodule

// ----- rtl/pli_line.sv -----
`timescale 1ns / 1ps
module pli_line import pli_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  line_req_type      req,
   output logic              done,
   output logic [DATA_W-1:0] y
);

   typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_type;

   lstate_type        state_ff;
   logic [6:0]        cnt_ff;
   logic [65:0]       acc_ff, mcand_ff;
   logic [32:0]       mplier_ff, dmag_ff;
   logic [33:0]       rem_ff;
   logic              neg_ff, done_ff;
   logic [DATA_W-1:0] y0_ff, y_ff;

   logic signed [32:0] dx, dy, den;
   logic [32:0]        dx_mag, dy_mag, den_mag;
   logic               neg_in;
   logic [33:0]        rem_sh, rem_sub;
   logic               q_bit;
   logic               q_big;
   logic signed [35:0] q_s, sum;
   logic [DATA_W-1:0]  y_sat;

   assign dx  = $signed({req.x[31], req.x})   - $signed({req.x0[31], req.x0});
   assign dy  = $signed({req.y1[31], req.y1}) - $signed({req.y0[31], req.y0});
   assign den = $signed({req.x1[31], req.x1}) - $signed({req.x0[31], req.x0});
   assign dx_mag  = dx[32]  ? 33'(-dx)  : 33'(dx);
   assign dy_mag  = dy[32]  ? 33'(-dy)  : 33'(dy);
   assign den_mag = den[32] ? 33'(-den) : 33'(den);
   assign neg_in  = (dx == '0 || dy == '0) ? 1'b0 : ((dx[32] ^ dy[32]) ^ den[32]);

   // restoring divide step
   assign rem_sh  = {rem_ff[32:0], acc_ff[65]};
   assign q_bit   = rem_sh >= {1'b0, dmag_ff};
   assign rem_sub = rem_sh - {1'b0, dmag_ff};

   // saturation of y0 +/- quotient
   assign q_big = (acc_ff[65:34] != '0) || (acc_ff[33] && acc_ff[32:0] != '0);
   assign q_s   = neg_ff ? -$signed({2'b00, acc_ff[33:0]}) : $signed({2'b00, acc_ff[33:0]});
   assign sum   = q_s + 36'(signed'(y0_ff));
   always_comb begin
      if (q_big) begin
         y_sat = neg_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (sum > 36'sh0_7fff_ffff) begin
         y_sat = 32'h7fff_ffff;
      end else if (sum < -36'sh0_8000_0000) begin
         y_sat = 32'h8000_0000;
      end else begin
         y_sat = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  acc_ff    <= '0;
                  mcand_ff  <= {33'd0, dy_mag};
                  mplier_ff <= dx_mag;
                  dmag_ff   <= den_mag;
                  neg_ff    <= neg_in;
                  y0_ff     <= req.y0;
                  cnt_ff    <= '0;
                  state_ff  <= L_MUL;
               end
            end
            L_MUL: begin
               if (mplier_ff[0]) begin
                  acc_ff <= acc_ff + mcand_ff;
               end
               mcand_ff  <= {mcand_ff[64:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[32:1]};
               cnt_ff    <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd32) begin
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  state_ff <= L_DIV;
               end
            end
            L_DIV: begin
               rem_ff <= q_bit ? rem_sub : rem_sh;
               acc_ff <= {acc_ff[64:0], q_bit};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd65) begin
                  state_ff <= L_FIN;
               end
            end
            L_FIN: begin
               y_ff     <= y_sat;
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign y    = y_ff;

endmodule

// ----- rtl/piecewise_linear_interpolator_core.sv -----
`timescale 1ns / 1ps
// piecewise linear interpolator: the table points live in a row of MAX_POINTS cells,
// one point per cell; a load beat writes its cell and returns an empty result. a
// query beat sends a search record down the row, one cell per cycle; extrapolation
// needs a second scan. the line value then goes through a shared shift-add
// multiplier and a restoring divider. one beat is in work at a time; a finished
// result waits in the output register while the next beat is taken.
module piecewise_linear_interpolator_core import pli_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request beats
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [IDX_W-1:0]     req_point_index,
   input  logic signed [31:0]   req_x_value,
   input  logic signed [31:0]   req_y_value,
   // response beats
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_result_y,
   output logic                 rsp_result_valid,
   output logic [1:0]           rsp_result_kind,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_SCAN2, S_LINE, S_DONE} state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   point_count_ff;
   logic               extrap_en_ff;
   logic [CNT_W-1:0]   n_eff;

   // pending result and output register
   logic [DATA_W-1:0]  res_y_ff;
   logic               res_valid_ff;
   logic [1:0]         res_kind_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_y_ff;
   logic               rsp_rv_ff;
   logic [1:0]         rsp_kind_ff;

   // query context
   logic [DATA_W-1:0]  qx_ff;
   logic               side_lo_ff;      // second scan looks below the anchor
   logic [DATA_W-1:0]  p0_x_ff, p0_y_ff;

   // cell row
   scan_rec_type       chain [0:MAX_POINTS];
   scan_rec_type       launch_ff;
   scan_rec_type       tail;
   logic [MAX_POINTS-1:0] chain_vld;

   logic               req_acc, load_acc;
   logic               line_start_ff, line_done;
   line_req_type       line_req_ff;
   logic [DATA_W-1:0]  line_y;
   logic               out_free;

   assign req_acc   = req_valid && !req_stall;
   assign load_acc  = req_acc && req_func == FUNC_LOAD;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // slots past the table size never take part
   assign n_eff = (point_count_ff > MAX_POINTS_CNT) ? MAX_POINTS_CNT : point_count_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         extrap_en_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POINT_COUNT: point_count_ff <= csr_wdata;
            REG_EXTRAP_EN:   extrap_en_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign chain[0] = launch_ff;
   assign tail     = chain[MAX_POINTS];

   genvar g;
   generate
      for (g = 0; g < MAX_POINTS; g++) begin : g_cell
         pli_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (IDX_W'(g)),
            .n_eff      (n_eff),
            .wr_en      (load_acc && req_point_index == IDX_W'(g)),
            .wr_x       (req_x_value),
            .wr_y       (req_y_value),
            .rec_in     (chain[g]),
            .rec_out    (chain[g+1])
         );
         assign chain_vld[g] = chain[g+1].vld;
      end
   endgenerate

   pli_line u_line (
      .clock (clock),
      .reset (reset),
      .start (line_start_ff),
      .req   (line_req_ff),
      .done  (line_done),
      .y     (line_y)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launch_ff.vld <= 1'b0;
         line_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         launch_ff.vld <= 1'b0;
         line_start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  res_y_ff     <= '0;
                  res_valid_ff <= 1'b0;
                  res_kind_ff  <= KIND_NONE;
                  if (req_func == FUNC_LOAD) begin
                     state_ff <= S_DONE;
                  end else begin
                     qx_ff              <= req_x_value;
                     launch_ff          <= '0;
                     launch_ff.vld      <= 1'b1;
                     launch_ff.exact_en <= 1'b1;
                     launch_ff.qx       <= req_x_value;
                     state_ff           <= S_SCAN1;
                  end
               end
            end
            S_SCAN1: begin
               if (tail.vld) begin
                  if (tail.hit) begin
                     res_y_ff     <= tail.hit_y;
                     res_valid_ff <= 1'b1;
                     res_kind_ff  <= KIND_EXACT;
                     state_ff     <= S_DONE;
                  end else if (tail.has_lo && tail.has_hi) begin
                     line_req_ff   <= '{x: qx_ff, x0: tail.lo_x, y0: tail.lo_y,
                                        x1: tail.hi_x, y1: tail.hi_y};
                     line_start_ff <= 1'b1;
                     res_kind_ff   <= KIND_INTERP;
                     state_ff      <= S_LINE;
                  end else if (extrap_en_ff && (tail.has_lo || tail.has_hi)) begin
                     // rescan around the one neighbor found
                     side_lo_ff    <= tail.has_lo;
                     p0_x_ff       <= tail.has_lo ? tail.lo_x : tail.hi_x;
                     p0_y_ff       <= tail.has_lo ? tail.lo_y : tail.hi_y;
                     launch_ff     <= '0;
                     launch_ff.vld <= 1'b1;
                     launch_ff.qx  <= tail.has_lo ? tail.lo_x : tail.hi_x;
                     state_ff      <= S_SCAN2;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SCAN2: begin
               if (tail.vld) begin
                  if (side_lo_ff && tail.has_lo) begin
                     line_req_ff   <= '{x: qx_ff, x0: p0_x_ff, y0: p0_y_ff,
                                        x1: tail.lo_x, y1: tail.lo_y};
                     line_start_ff <= 1'b1;
                     res_kind_ff   <= KIND_EXTRAP;
                     state_ff      <= S_LINE;
                  end else if (!side_lo_ff && tail.has_hi) begin
                     line_req_ff   <= '{x: qx_ff, x0: p0_x_ff, y0: p0_y_ff,
                                        x1: tail.hi_x, y1: tail.hi_y};
                     line_start_ff <= 1'b1;
                     res_kind_ff   <= KIND_EXTRAP;
                     state_ff      <= S_LINE;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_LINE: begin
               if (line_done) begin
                  res_y_ff     <= line_y;
                  res_valid_ff <= 1'b1;
                  state_ff     <= S_DONE;
               end
            end
            S_DONE: begin
               // hand the result over once the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_y_ff     <= res_y_ff;
                  rsp_rv_ff    <= res_valid_ff;
                  rsp_kind_ff  <= res_valid_ff ? res_kind_ff : KIND_NONE;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_y     = rsp_y_ff;
   assign rsp_result_valid = rsp_rv_ff;
   assign rsp_result_kind  = rsp_kind_ff;

   // at most one search record in the row
   a_one_record: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_vld) <= 1)
      else $error("more than one search record in the cell row");

   // the line unit only finishes while the sequencer waits for it
   a_line_done: assert property (@(posedge clock) disable iff (reset)
      line_done |-> state_ff == S_LINE)
      else $error("line unit finished outside of the line state");

   // an invalid result carries zero and kind none
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_valid) |-> (rsp_result_y == '0 && rsp_result_kind == KIND_NONE))
      else $error("invalid result with nonzero payload");

   // a valid result always names its kind
   a_valid_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_valid) |-> rsp_result_kind != KIND_NONE)
      else $error("valid result with kind none");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import pli_pkg::*;

   // one request beat and one response beat as the block sees them
   typedef struct {
      logic               func;
      logic [IDX_W-1:0]   slot;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_op_type;

   typedef struct {
      logic signed [31:0] y;
      logic               ok;
      logic [1:0]         kind;
   } interp_res_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PRESSURE_HOLD  = 600;
   localparam int DRAIN_CYCLES   = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = FUNC_LOAD;
   logic [IDX_W-1:0]     req_point_index = '0;
   logic signed [31:0]   req_x_value = '0;
   logic signed [31:0]   req_y_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   logic signed [31:0]   rsp_result_y;
   logic                 rsp_result_valid;
   logic [1:0]           rsp_result_kind;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_POINT_COUNT;
   logic [CNT_W-1:0]     csr_wdata = '0;

   piecewise_linear_interpolator_core i_dut (.*);

   always #10 clock = ~clock;

   // predictor copy of the table and the registers
   logic signed [31:0] pt_x [MAX_POINTS];
   logic signed [31:0] pt_y [MAX_POINTS];
   logic [CNT_W-1:0]   cur_count = '0;
   logic               cur_extrap = 1'b0;

   point_op_type   pending_ops [$];
   interp_res_type expected_res [$];

   int errors = 0;
   int cycle = 0;
   int idle_cycles = 0;
   int rsp_count = 0;
   int kind_tally [4] = '{0, 0, 0, 0};
   int sat_count = 0;
   logic req_fire = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   logic pressed = 1'b0;

   // mostly short gaps, a few long ones, and quiet windows with none at all
   function automatic int gap_len();
      int r;
      if ((cycle / 2000) % 4 == 0) return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // y0 + (x - x0) * (y1 - y0) / (x1 - x0), truncated toward zero, saturated
   function automatic logic signed [31:0] line_value(input logic signed [31:0] x, x0, y0,
                                                      x1, y1);
      longint dx, dy, den, s;
      logic [63:0] mdx, mdy, mden, q;
      logic neg;
      dx  = longint'(x) - longint'(x0);
      dy  = longint'(y1) - longint'(y0);
      den = longint'(x1) - longint'(x0);
      mdx  = (dx < 0) ? -dx : dx;
      mdy  = (dy < 0) ? -dy : dy;
      mden = (den < 0) ? -den : den;
      neg = ((dx < 0) != (dy < 0)) != (den < 0);
      if (dx == 0 || dy == 0) neg = 1'b0;
      q = (mdx * mdy) / mden;
      if (q > 64'h2_0000_0000) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      s = neg ? -longint'(q) : longint'(q);
      s = s + longint'(y0);
      if (s > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
      if (s < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
      return s[31:0];
   endfunction

   // applies one beat to the table copy and returns the response it should give
   function automatic interp_res_type predict_lookup(input point_op_type op);
      interp_res_type r;
      int n, lo, hi, sec;
      r = '{0, 1'b0, KIND_NONE};
      if (op.func == FUNC_LOAD) begin
         pt_x[op.slot] = op.x;
         pt_y[op.slot] = op.y;
         return r;
      end
      n = (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
      lo = -1;
      hi = -1;
      sec = -1;
      for (int i = 0; i < n; i++) begin
         // lowest slot wins on an exact hit
         if (pt_x[i] == op.x) begin
            r = '{pt_y[i], 1'b1, KIND_EXACT};
            return r;
         end
         if (pt_x[i] < op.x && (lo < 0 || pt_x[i] > pt_x[lo])) lo = i;
         if (pt_x[i] > op.x && (hi < 0 || pt_x[i] < pt_x[hi])) hi = i;
      end
      if (lo >= 0 && hi >= 0) begin
         r = '{line_value(op.x, pt_x[lo], pt_y[lo], pt_x[hi], pt_y[hi]), 1'b1, KIND_INTERP};
      end else if (cur_extrap && lo >= 0) begin
         for (int i = 0; i < n; i++)
            if (pt_x[i] < pt_x[lo] && (sec < 0 || pt_x[i] > pt_x[sec])) sec = i;
         if (sec >= 0)
            r = '{line_value(op.x, pt_x[lo], pt_y[lo], pt_x[sec], pt_y[sec]), 1'b1,
                  KIND_EXTRAP};
      end else if (cur_extrap && hi >= 0) begin
         for (int i = 0; i < n; i++)
            if (pt_x[i] > pt_x[hi] && (sec < 0 || pt_x[i] < pt_x[sec])) sec = i;
         if (sec >= 0)
            r = '{line_value(op.x, pt_x[hi], pt_y[hi], pt_x[sec], pt_y[sec]), 1'b1,
                  KIND_EXTRAP};
      end
      return r;
   endfunction

   function automatic logic rsp_result_ok_sat(input logic signed [31:0] y, input logic ok);
      return ok && (y == 32'sh7fff_ffff || y == 32'sh8000_0000);
   endfunction

   // request driver: new beat only after the previous one was taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            point_op_type op;
            op = pending_ops.pop_front();
            req_func        <= op.func;
            req_point_index <= op.slot;
            req_x_value     <= op.x;
            req_y_value     <= op.y;
            req_valid       <= 1'b1;
            send_gap        <= gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random stalls plus one long hold-off to back the block up
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!pressed && rsp_count >= 100) begin
            pressed <= 1'b1;
            hold_left <= PRESSURE_HOLD;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(99) < 30) stall_left <= gap_len();
         end
      end
   end

   // monitor: every handshake is seen here at the rising edge
   always @(posedge clock) begin
      point_op_type op;
      interp_res_type want;
      logic any;
      cycle <= cycle + 1;
      any = 1'b0;
      req_fire <= req_valid && !req_stall;
      if (!reset && csr_valid && csr_ready) begin
         any = 1'b1;
         if (csr_index == REG_POINT_COUNT) cur_count = csr_wdata;
         else if (csr_index == REG_EXTRAP_EN) cur_extrap = csr_wdata[0];
      end
      if (!reset && req_valid && !req_stall) begin
         any = 1'b1;
         op = '{req_func, req_point_index, req_x_value, req_y_value};
         expected_res.push_back(predict_lookup(op));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         any = 1'b1;
         rsp_count <= rsp_count + 1;
         if (expected_res.size() == 0) begin
            $error("response beat with nothing expected: y=%h kind=%0d", rsp_result_y,
                   rsp_result_kind);
            errors++;
         end else begin
            want = expected_res.pop_front();
            kind_tally[rsp_result_kind]++;
            if (rsp_result_ok_sat(rsp_result_y, rsp_result_valid)) sat_count++;
            if (rsp_result_y !== want.y) begin
               $error("result_y mismatch: expected %h, got %h", want.y, rsp_result_y);
               errors++;
            end
            if (rsp_result_valid !== want.ok) begin
               $error("result_valid mismatch: expected %0d, got %0d", want.ok,
                      rsp_result_valid);
               errors++;
            end
            if (rsp_result_kind !== want.kind) begin
               $error("result_kind mismatch: expected %0d, got %0d", want.kind,
                      rsp_result_kind);
               errors++;
            end
         end
      end
      // watchdog on cycles with no handshake at all
      if (reset || any) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_op(input logic func, input int slot, input logic signed [31:0] x,
                          input logic signed [31:0] y);
      pending_ops.push_back('{func, slot[IDX_W-1:0], x, y});
   endtask

   // waits until every beat is out, then a pause for the block to settle
   task automatic wait_idle();
      while (pending_ops.size() > 0 || req_valid || expected_res.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= value[CNT_W-1:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_mode(input int count, input int extrap);
      wait_idle();
      csr_write(REG_POINT_COUNT, count);
      csr_write(REG_EXTRAP_EN, extrap);
   endtask

   // random query abscissa, biased toward the points in use
   function automatic logic signed [31:0] pick_query_x(input int n);
      int s;
      s = (n > 0) ? $urandom_range(((n > MAX_POINTS) ? MAX_POINTS : n) - 1) : 0;
      case ($urandom_range(5))
         0, 1: return pt_x[s];
         2: return pt_x[s] + $signed($urandom_range(0, 200)) - 100;
         3: return $urandom();
         4: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      endcase
   endfunction

   // random point, half of them on a coarse grid so ties and neighbors are common
   task automatic push_random_load();
      logic signed [31:0] x, y;
      case ($urandom_range(3))
         0: x = $urandom();
         1: x = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: x = ($signed($urandom_range(0, 63)) - 32) <<< 16;
      endcase
      y = ($urandom_range(4) == 0) ? $urandom() :
          $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
      push_op(FUNC_LOAD, $urandom_range(MAX_POINTS - 1), x, y);
   endtask

   initial begin
      int modes [8][2] = '{'{64, 1}, '{127, 0}, '{2, 1}, '{16, 0},
                           '{40, 1}, '{64, 0}, '{3, 1}, '{127, 1}};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every slot so no query can ever read an unwritten one
      for (int i = 0; i < MAX_POINTS; i++)
         push_op(FUNC_LOAD, i, (i - 32) <<< 16, $urandom());
      // empty table scan after reset
      push_op(FUNC_QUERY, 0, 0, 0);

      // single point: exact hit, and one neighbor only on each side
      set_mode(1, 1);
      push_op(FUNC_QUERY, 0, -32 <<< 16, 0);
      push_op(FUNC_QUERY, 0, 32'sh8000_0000, 0);
      push_op(FUNC_QUERY, 0, 32'sh7fff_ffff, 0);

      // extremes, a tie on x and saturation
      set_mode(6, 0);
      push_op(FUNC_LOAD, 0, 32'sh8000_0000, 0);
      push_op(FUNC_LOAD, 1, 0, 100);
      push_op(FUNC_LOAD, 2, 0, 200);
      push_op(FUNC_LOAD, 3, 32'sh7fff_ffff, 32'sh7fff_ffff);
      push_op(FUNC_LOAD, 4, 32'sh0001_0000, 32'sh8000_0000);
      push_op(FUNC_LOAD, 5, 32'sh0002_0000, 32'sh7fff_ffff);
      push_op(FUNC_QUERY, 0, 0, 0);
      push_op(FUNC_QUERY, 0, 32'sh0000_8000, 0);
      push_op(FUNC_QUERY, 0, 32'sh0001_8000, 0);
      push_op(FUNC_QUERY, 0, 32'sh8000_0000, 0);
      push_op(FUNC_QUERY, 0, 32'sh7fff_ffff, 0);
      push_op(FUNC_QUERY, 0, -1, 0);
      push_op(FUNC_QUERY, 0, 32'sh4000_0000, 0);

      // only points below or above the query: extrapolation on and off
      set_mode(3, 1);
      push_op(FUNC_QUERY, 0, 5, 0);
      push_op(FUNC_QUERY, 0, 32'sh7fff_ffff, 0);
      set_mode(3, 0);
      push_op(FUNC_QUERY, 0, 5, 0);
      push_op(FUNC_LOAD, 0, 32'sh0000_1000, -77);
      push_op(FUNC_QUERY, 0, -5, 0);

      // random phases across register settings
      for (int m = 0; m < 8; m++) begin
         set_mode(modes[m][0], modes[m][1]);
         for (int k = 0; k < 150; k++) begin
            if ($urandom_range(99) < 30) push_random_load();
            else push_op(FUNC_QUERY, $urandom_range(MAX_POINTS - 1),
                         pick_query_x(modes[m][0]), $urandom());
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_res.size() > 0) begin
         $error("%0d expected responses never arrived", expected_res.size());
         errors++;
      end
      $display("covered %0d responses: %0d empty, %0d exact, %0d interpolated, %0d extrapolated",
               rsp_count, kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
      $display("saturated results %0d, long response hold-off done: %0d", sat_count, pressed);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pli_pkg.sv
rtl/pli_cell.sv
rtl/pli_line.sv
rtl/piecewise_linear_interpolator_core.sv
verif/tb.sv
